FILE: hw/rtl/pce_pkg.sv
package pce_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int RADIUS_W   = 32;
    localparam int SWIDTH_W   = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STROKE_W  = 3'd3;

    // Left shift applied to a product before it is accumulated
    typedef enum logic [1:0] {
        SH_0,
        SH_H,
        SH_H1,
        SH_2H
    } t_shift;

    // What to take from the accumulator once a group of products is summed
    typedef enum logic [2:0] {
        EV_NONE,
        EV_IN_S,
        EV_IN_E,
        EV_DOT1,
        EV_DOT2,
        EV_CROSS,
        EV_LEN,
        EV_FIN
    } t_eval;

    // One multiply-accumulate command
    typedef struct packed {
        logic   valid;
        logic   clear;
        logic   sub_r;
        logic   neg;
        t_shift sh;
        t_eval  ev;
    } t_mac_ctl;

    // Test outcomes left by the shared unit
    typedef struct packed {
        logic in_s;
        logic in_e;
        logic dot1;
        logic dot2;
        logic fin_neg;
    } t_mac_flags;

    // Product schedule for one segment
    typedef enum logic [4:0] {
        ST_IN_S_X,
        ST_IN_S_Y,
        ST_IN_E_X,
        ST_IN_E_Y,
        ST_DOT1_X,
        ST_DOT1_Y,
        ST_DOT2_X,
        ST_DOT2_Y,
        ST_CR_P,
        ST_CR_Q,
        ST_LEN_X,
        ST_LEN_Y,
        ST_SQ_LO,
        ST_SQ_MID,
        ST_SQ_HI,
        ST_R_LO,
        ST_R_HI
    } t_step;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FINISH
    } t_state;

endpackage

FILE: hw/rtl/pce_mac.sv
module pce_mac
    import pce_pkg::*;
#(
    parameter int COORD_BITS = 16,
    localparam int MW  = (COORD_BITS + 1 > RADIUS_W) ? COORD_BITS + 1 : RADIUS_W,
    localparam int CMW = 2 * COORD_BITS + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mac_ctl         i_ctl,
    input  logic [MW-1:0]    i_op_a,
    input  logic [MW-1:0]    i_op_b,
    input  logic [RADIUS_W-1:0] i_radius,
    output t_mac_flags       o_flags,
    output logic [CMW-1:0]   o_cm,
    output logic [CMW-1:0]   o_l2
);

    localparam int C   = COORD_BITS;
    localparam int H   = C + 1;
    localparam int AW  = ((4 * C + 2 > 2 * C + RADIUS_W + 1) ? 4 * C + 2
                                                             : 2 * C + RADIUS_W + 1) + 1;
    localparam int XW  = (AW > 2 * MW) ? AW : 2 * MW;

    logic [2*MW-1:0]        r_prod;
    t_mac_ctl               r_ctl;
    logic signed [AW-1:0]   r_acc;
    logic signed [AW-1:0]   n_acc;
    t_eval                  r_ev;
    t_mac_flags             r_flags;
    logic [CMW-1:0]         r_cm;
    logic [CMW-1:0]         r_l2;

    logic [XW-1:0]          prod_ext;
    logic [XW-1:0]          shifted;
    logic signed [AW-1:0]   term;
    logic signed [AW-1:0]   base;
    logic signed [AW-1:0]   acc_abs;
    logic                   acc_pos;

    // Stage 1: the multiplier
    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_prod <= i_op_a * i_op_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // Stage 2: shift, then add or subtract into the accumulator
    always_comb begin
        prod_ext = XW'(r_prod);
        case (r_ctl.sh)
            SH_0:    shifted = prod_ext;
            SH_H:    shifted = prod_ext << H;
            SH_H1:   shifted = prod_ext << (H + 1);
            SH_2H:   shifted = prod_ext << (2 * H);
            default: shifted = prod_ext;
        endcase
        term = signed'(shifted[AW-1:0]);
        if (r_ctl.clear) begin
            base = r_ctl.sub_r ? -signed'(AW'(i_radius)) : '0;
        end else begin
            base = r_acc;
        end
        n_acc = r_ctl.neg ? base - term : base + term;
    end

    always_ff @(posedge i_clk) begin
        if (r_ctl.valid) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= EV_NONE;
        end else begin
            r_ev <= r_ctl.valid ? r_ctl.ev : EV_NONE;
        end
    end

    // Stage 3: sign tests and stored results
    assign acc_abs = r_acc[AW-1] ? -r_acc : r_acc;
    assign acc_pos = !r_acc[AW-1] && (|r_acc);

    always_ff @(posedge i_clk) begin
        unique case (r_ev)
            EV_IN_S:  r_flags.in_s    <= r_acc[AW-1];
            EV_IN_E:  r_flags.in_e    <= r_acc[AW-1];
            EV_DOT1:  r_flags.dot1    <= acc_pos;
            EV_DOT2:  r_flags.dot2    <= acc_pos;
            EV_CROSS: r_cm            <= acc_abs[CMW-1:0];
            EV_LEN:   r_l2            <= r_acc[CMW-1:0];
            EV_FIN:   r_flags.fin_neg <= r_acc[AW-1];
            default: ;
        endcase
    end

    assign o_flags = r_flags;
    assign o_cm    = r_cm;
    assign o_l2    = r_l2;

endmodule

FILE: hw/rtl/pce_box.sv
module pce_box
    import pce_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_upd,
    input  logic                         i_hit,
    input  logic                         i_last,
    input  logic signed [COORD_BITS-1:0] i_sx,
    input  logic signed [COORD_BITS-1:0] i_sy,
    input  logic signed [COORD_BITS-1:0] i_ex,
    input  logic signed [COORD_BITS-1:0] i_ey,
    input  logic [SWIDTH_W-1:0]          i_width,
    output logic                         o_valid,
    output logic signed [COORD_BITS-1:0] o_min_x,
    output logic signed [COORD_BITS-1:0] o_min_y,
    output logic signed [COORD_BITS-1:0] o_max_x,
    output logic signed [COORD_BITS-1:0] o_max_y
);

    localparam int C  = COORD_BITS;
    localparam int EW = C + SWIDTH_W + 2;
    localparam logic signed [EW-1:0] SAT_HI = signed'({{(EW-C+1){1'b0}}, {(C-1){1'b1}}});
    localparam logic signed [EW-1:0] SAT_LO = signed'({{(EW-C+1){1'b1}}, {(C-1){1'b0}}});

    logic                  r_valid;
    logic signed [C-1:0]   r_min_x;
    logic signed [C-1:0]   r_min_y;
    logic signed [C-1:0]   r_max_x;
    logic signed [C-1:0]   r_max_y;

    logic                  fit_valid;
    logic signed [C-1:0]   fit_min_x;
    logic signed [C-1:0]   fit_min_y;
    logic signed [C-1:0]   fit_max_x;
    logic signed [C-1:0]   fit_max_y;

    function automatic logic signed [C-1:0] smin(input logic signed [C-1:0] a,
                                                 input logic signed [C-1:0] b);
        smin = (a < b) ? a : b;
    endfunction

    function automatic logic signed [C-1:0] smax(input logic signed [C-1:0] a,
                                                 input logic signed [C-1:0] b);
        smax = (a > b) ? a : b;
    endfunction

    // Edge moved up (max side) or down (min side) by the stroke width, clamped to range
    function automatic logic signed [C-1:0] grow(input logic signed [C-1:0] v,
                                                 input logic [SWIDTH_W-1:0] w,
                                                 input logic up);
        logic signed [EW-1:0] ve;
        logic signed [EW-1:0] we;
        logic signed [EW-1:0] s;
        ve = signed'({{(EW-C){v[C-1]}}, v});
        we = signed'({{(EW-SWIDTH_W){1'b0}}, w});
        s  = up ? ve + we : ve - we;
        if (s > SAT_HI) begin
            grow = SAT_HI[C-1:0];
        end else if (s < SAT_LO) begin
            grow = SAT_LO[C-1:0];
        end else begin
            grow = s[C-1:0];
        end
    endfunction

    // Box including the current segment when it is hit
    always_comb begin
        fit_valid = r_valid || i_hit;
        fit_min_x = r_min_x;
        fit_min_y = r_min_y;
        fit_max_x = r_max_x;
        fit_max_y = r_max_y;
        if (i_hit) begin
            fit_min_x = smin(i_sx, i_ex);
            fit_min_y = smin(i_sy, i_ey);
            fit_max_x = smax(i_sx, i_ex);
            fit_max_y = smax(i_sy, i_ey);
            if (r_valid) begin
                fit_min_x = smin(fit_min_x, r_min_x);
                fit_min_y = smin(fit_min_y, r_min_y);
                fit_max_x = smax(fit_max_x, r_max_x);
                fit_max_y = smax(fit_max_y, r_max_y);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_upd) begin
            r_valid <= fit_valid && !i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd) begin
            r_min_x <= fit_min_x;
            r_min_y <= fit_min_y;
            r_max_x <= fit_max_x;
            r_max_y <= fit_max_y;
        end
    end

    assign o_valid = fit_valid;
    assign o_min_x = grow(fit_min_x, i_width, 1'b0);
    assign o_min_y = grow(fit_min_y, i_width, 1'b0);
    assign o_max_x = grow(fit_max_x, i_width, 1'b1);
    assign o_max_y = grow(fit_max_y, i_width, 1'b1);

endmodule

FILE: hw/rtl/polyline_circle_eraser_core.sv
// Eraser test for one pen stroke. Points arrive in order, the last one flagged; each
// point after the first closes a segment that is tested exactly against the eraser
// circle (end inside, or perpendicular foot between the ends and closer than the
// radius), all in integer arithmetic on one shared multiplier. A point that closes a
// segment issues seventeen products back to back through the multiplier, drains its
// accumulate and evaluate stages, then posts the word; a first point posts with no
// products. No new point is taken until the word is posted. The result word sits in
// an output register, so the next point is accepted while it waits; a word that is
// still waiting when the following one is ready holds the block in its posting cycle.
// On the last point the word also carries the box around all hit segments, grown by
// the stroke width and clamped to the coordinate range. The user must write
// configuration only while no point is in flight; the block does not enforce it.
module polyline_circle_eraser_core
    import pce_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_wdata,
    // point input
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic                         i_last_point,
    // result output
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_segment_valid,
    output logic                         o_segment_hit,
    output logic                         o_cut_here,
    output logic                         o_restart_here,
    output logic                         o_area_valid,
    output logic signed [COORD_BITS-1:0] o_area_min_x,
    output logic signed [COORD_BITS-1:0] o_area_min_y,
    output logic signed [COORD_BITS-1:0] o_area_max_x,
    output logic signed [COORD_BITS-1:0] o_area_max_y,
    output logic                         o_stroke_done
);

    localparam int C   = COORD_BITS;
    localparam int H   = C + 1;
    localparam int MW  = (C + 1 > RADIUS_W) ? C + 1 : RADIUS_W;
    localparam int CMW = 2 * C + 1;

    // Configuration registers
    logic signed [C-1:0]     r_center_x;
    logic signed [C-1:0]     r_center_y;
    logic [RADIUS_W-1:0]     r_radius_sq;
    logic [SWIDTH_W-1:0]     r_stroke_w;

    // Point and stroke state
    logic signed [C-1:0]     r_ex;
    logic signed [C-1:0]     r_ey;
    logic                    r_last;
    logic signed [C-1:0]     r_prev_x;
    logic signed [C-1:0]     r_prev_y;
    logic                    r_have_prev;
    logic                    r_in_run;

    // Sequencer
    t_state                  r_state;
    t_state                  n_state;
    t_step                   r_step;
    t_step                   n_step;
    logic                    r_drain;
    logic                    n_drain;
    logic                    in_accept;
    logic                    out_free;
    logic                    finish;

    // Shared unit interface
    t_mac_ctl                mac_ctl;
    logic [MW-1:0]           op_a;
    logic [MW-1:0]           op_b;
    t_mac_flags              mac_flags;
    logic [CMW-1:0]          mac_cm;
    logic [CMW-1:0]          mac_l2;

    logic signed [C-1:0]     a1;
    logic signed [C-1:0]     a2;
    logic signed [C-1:0]     b1;
    logic signed [C-1:0]     b2;
    logic signed [C:0]       da;
    logic signed [C:0]       db;
    logic [C:0]              ma;
    logic [C:0]              mb;
    logic                    use_wide;
    logic                    sub_term;
    logic [MW-1:0]           wide_a;
    logic [MW-1:0]           wide_b;

    // Segment outcome
    logic                    seg_hit;
    logic                    seg_cut;
    logic                    seg_restart;
    logic                    box_valid;
    logic signed [C-1:0]     box_min_x;
    logic signed [C-1:0]     box_min_y;
    logic signed [C-1:0]     box_max_x;
    logic signed [C-1:0]     box_max_y;
    logic                    area_on;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x  <= '0;
            r_center_y  <= '0;
            r_radius_sq <= '0;
            r_stroke_w  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CENTER_X:  r_center_x  <= i_cfg_wdata[C-1:0];
                CFG_CENTER_Y:  r_center_y  <= i_cfg_wdata[C-1:0];
                CFG_RADIUS_SQ: r_radius_sq <= i_cfg_wdata[RADIUS_W-1:0];
                CFG_STROKE_W:  r_stroke_w  <= i_cfg_wdata[SWIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !o_out_valid || !i_out_stall;

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_drain = r_drain;
        finish  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_step  = ST_IN_S_X;
                    n_state = r_have_prev ? S_RUN : S_FINISH;
                end
            end
            S_RUN: begin
                if (r_step == ST_R_HI) begin
                    n_state = S_DRAIN;
                    n_drain = 1'b0;
                end else begin
                    n_step = t_step'(r_step + 5'd1);
                end
            end
            S_DRAIN: begin
                if (r_drain) begin
                    n_state = S_FINISH;
                end else begin
                    n_drain = 1'b1;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    finish  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= ST_IN_S_X;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_drain <= n_drain;
        end
    end

    // Capture the point
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ex   <= i_point_x;
            r_ey   <= i_point_y;
            r_last <= i_last_point;
        end
    end

    // Product schedule: operand pairs and accumulate commands
    always_comb begin
        a1       = r_center_x;
        a2       = r_prev_x;
        b1       = r_center_x;
        b2       = r_prev_x;
        use_wide = 1'b0;
        wide_a   = '0;
        wide_b   = '0;
        sub_term = 1'b0;
        mac_ctl  = '0;
        mac_ctl.valid = (r_state == S_RUN);
        mac_ctl.sh    = SH_0;
        mac_ctl.ev    = EV_NONE;
        unique case (r_step)
            // start point inside: (c - s)^2 summed, minus r^2
            ST_IN_S_X: begin
                mac_ctl.clear = 1'b1;
                mac_ctl.sub_r = 1'b1;
            end
            ST_IN_S_Y: begin
                a1 = r_center_y; a2 = r_prev_y; b1 = r_center_y; b2 = r_prev_y;
                mac_ctl.ev = EV_IN_S;
            end
            // end point inside
            ST_IN_E_X: begin
                a2 = r_ex; b2 = r_ex;
                mac_ctl.clear = 1'b1;
                mac_ctl.sub_r = 1'b1;
            end
            ST_IN_E_Y: begin
                a1 = r_center_y; a2 = r_ey; b1 = r_center_y; b2 = r_ey;
                mac_ctl.ev = EV_IN_E;
            end
            // v . (c - s)
            ST_DOT1_X: begin
                a1 = r_ex;
                mac_ctl.clear = 1'b1;
            end
            ST_DOT1_Y: begin
                a1 = r_ey; a2 = r_prev_y; b1 = r_center_y; b2 = r_prev_y;
                mac_ctl.ev = EV_DOT1;
            end
            // v . (e - c)
            ST_DOT2_X: begin
                a1 = r_ex; b1 = r_ex; b2 = r_center_x;
                mac_ctl.clear = 1'b1;
            end
            ST_DOT2_Y: begin
                a1 = r_ey; a2 = r_prev_y; b1 = r_ey; b2 = r_center_y;
                mac_ctl.ev = EV_DOT2;
            end
            // cross(v, c - s)
            ST_CR_P: begin
                a1 = r_ex; b1 = r_center_y; b2 = r_prev_y;
                mac_ctl.clear = 1'b1;
            end
            ST_CR_Q: begin
                a1 = r_ey; a2 = r_prev_y;
                sub_term   = 1'b1;
                mac_ctl.ev = EV_CROSS;
            end
            // |v|^2
            ST_LEN_X: begin
                a1 = r_ex; b1 = r_ex;
                mac_ctl.clear = 1'b1;
            end
            ST_LEN_Y: begin
                a1 = r_ey; a2 = r_prev_y; b1 = r_ey; b2 = r_prev_y;
                mac_ctl.ev = EV_LEN;
            end
            // cross^2 - r^2 * |v|^2 from half-width pieces
            ST_SQ_LO: begin
                use_wide = 1'b1;
                wide_a   = MW'(mac_cm[H-1:0]);
                wide_b   = MW'(mac_cm[H-1:0]);
                mac_ctl.clear = 1'b1;
            end
            ST_SQ_MID: begin
                use_wide = 1'b1;
                wide_a   = MW'(mac_cm[CMW-1:H]);
                wide_b   = MW'(mac_cm[H-1:0]);
                mac_ctl.sh = SH_H1;
            end
            ST_SQ_HI: begin
                use_wide = 1'b1;
                wide_a   = MW'(mac_cm[CMW-1:H]);
                wide_b   = MW'(mac_cm[CMW-1:H]);
                mac_ctl.sh = SH_2H;
            end
            ST_R_LO: begin
                use_wide = 1'b1;
                wide_a   = MW'(r_radius_sq);
                wide_b   = MW'(mac_l2[H-1:0]);
                sub_term = 1'b1;
            end
            ST_R_HI: begin
                use_wide = 1'b1;
                wide_a   = MW'(r_radius_sq);
                wide_b   = MW'(mac_l2[CMW-1:H]);
                sub_term = 1'b1;
                mac_ctl.sh = SH_H;
                mac_ctl.ev = EV_FIN;
            end
            default: ;
        endcase

        // signed differences to magnitude and sign
        da = signed'({a1[C-1], a1}) - signed'({a2[C-1], a2});
        db = signed'({b1[C-1], b1}) - signed'({b2[C-1], b2});
        ma = da[C] ? -da : da;
        mb = db[C] ? -db : db;
        op_a = use_wide ? wide_a : MW'(ma);
        op_b = use_wide ? wide_b : MW'(mb);
        mac_ctl.neg = (use_wide ? 1'b0 : (da[C] ^ db[C])) ^ sub_term;
    end

    pce_mac #(
        .COORD_BITS (COORD_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_op_a   (op_a),
        .i_op_b   (op_b),
        .i_radius (r_radius_sq),
        .o_flags  (mac_flags),
        .o_cm     (mac_cm),
        .o_l2     (mac_l2)
    );

    // Segment verdict
    assign seg_hit = r_have_prev && (mac_flags.in_s || mac_flags.in_e ||
                     (mac_flags.dot1 && mac_flags.dot2 && mac_flags.fin_neg));
    assign seg_cut     = seg_hit && !r_in_run;
    assign seg_restart = r_have_prev && !seg_hit && r_in_run;

    pce_box #(
        .COORD_BITS (COORD_BITS)
    ) u_box (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (finish),
        .i_hit   (seg_hit),
        .i_last  (r_last),
        .i_sx    (r_prev_x),
        .i_sy    (r_prev_y),
        .i_ex    (r_ex),
        .i_ey    (r_ey),
        .i_width (r_stroke_w),
        .o_valid (box_valid),
        .o_min_x (box_min_x),
        .o_min_y (box_min_y),
        .o_max_x (box_max_x),
        .o_max_y (box_max_y)
    );

    // Stroke state moves on when the word is posted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_in_run    <= 1'b0;
        end else if (finish) begin
            r_have_prev <= !r_last;
            r_in_run    <= r_last ? 1'b0 : (r_have_prev ? seg_hit : r_in_run);
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_prev_x <= r_ex;
            r_prev_y <= r_ey;
        end
    end

    // Output register
    assign area_on = r_last && box_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (finish) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            o_segment_valid <= r_have_prev;
            o_segment_hit   <= seg_hit;
            o_cut_here      <= seg_cut;
            o_restart_here  <= seg_restart;
            o_area_valid    <= area_on;
            o_area_min_x    <= area_on ? box_min_x : '0;
            o_area_min_y    <= area_on ? box_min_y : '0;
            o_area_max_x    <= area_on ? box_max_x : '0;
            o_area_max_y    <= area_on ? box_max_y : '0;
            o_stroke_done   <= r_last;
        end
    end

endmodule

FILE: sim/polyline_circle_eraser_core_tb.sv
module polyline_circle_eraser_core_tb;
    import pce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int IDLE_PCT    = 16;
    // first register index past the end of the register list
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_STROKE_W + CFG_IDX_W'(1);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 last;
    } t_pen_point;

    typedef struct packed {
        logic                 seg_valid;
        logic                 seg_hit;
        logic                 cut;
        logic                 restart;
        logic                 area_valid;
        logic signed [CW-1:0] min_x;
        logic signed [CW-1:0] min_y;
        logic signed [CW-1:0] max_x;
        logic signed [CW-1:0] max_y;
        logic                 done;
    } t_seg_word;

    // DUT pins, the inputs known from time zero
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                 i_in_valid   = 1'b0;
    logic signed [CW-1:0] i_point_x    = '0;
    logic signed [CW-1:0] i_point_y    = '0;
    logic                 i_last_point = 1'b0;
    logic                 i_out_stall  = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_segment_valid;
    logic                 o_segment_hit;
    logic                 o_cut_here;
    logic                 o_restart_here;
    logic                 o_area_valid;
    logic signed [CW-1:0] o_area_min_x;
    logic signed [CW-1:0] o_area_min_y;
    logic signed [CW-1:0] o_area_max_x;
    logic signed [CW-1:0] o_area_max_y;
    logic                 o_stroke_done;

    // eraser settings as the block should hold them
    logic signed [CW-1:0] ctr_x = '0;
    logic signed [CW-1:0] ctr_y = '0;
    logic [RADIUS_W-1:0]  rad_sq = '0;
    logic [SWIDTH_W-1:0]  pen_width = '0;

    // stroke tracking state
    logic signed [CW-1:0] prev_x = '0;
    logic signed [CW-1:0] prev_y = '0;
    logic                 have_prev = 1'b0;
    logic                 in_run = 1'b0;
    logic                 box_valid = 1'b0;
    int                   box_min_x = 0;
    int                   box_min_y = 0;
    int                   box_max_x = 0;
    int                   box_max_y = 0;

    t_pen_point point_q[$];
    t_seg_word  due_words[$];
    logic       word_taken = 1'b0;
    logic       calm = 1'b0;
    int         cycle_cnt = 0;
    int         bad_words = 0;
    int         words_seen = 0;
    int         queued_pts = 0;
    int         n_strokes = 0;
    int         n_hits = 0;
    int         n_cuts = 0;
    int         n_restarts = 0;
    int         n_areas = 0;
    int         n_settings = 0;

    polyline_circle_eraser_core #(
        .COORD_BITS(CW)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_last_point   (i_last_point),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_segment_valid(o_segment_valid),
        .o_segment_hit  (o_segment_hit),
        .o_cut_here     (o_cut_here),
        .o_restart_here (o_restart_here),
        .o_area_valid   (o_area_valid),
        .o_area_min_x   (o_area_min_x),
        .o_area_min_y   (o_area_min_y),
        .o_area_max_x   (o_area_max_x),
        .o_area_max_y   (o_area_max_y),
        .o_stroke_done  (o_stroke_done)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [CW-1:0] clamp_coord(input longint v);
        longint top;
        longint bot;
        top = (longint'(1) <<< (CW - 1)) - 1;
        bot = -top - 1;
        if (v > top) return top[CW-1:0];
        if (v < bot) return bot[CW-1:0];
        return v[CW-1:0];
    endfunction

    // strictly inside the eraser circle
    function automatic logic holds_point(input logic signed [CW-1:0] px,
                                         input logic signed [CW-1:0] py);
        longint dx, dy, rs;
        dx = longint'(ctr_x) - longint'(px);
        dy = longint'(ctr_y) - longint'(py);
        rs = longint'(rad_sq);
        return (dx * dx + dy * dy) < rs;
    endfunction

    // exact segment test: end inside, or foot strictly between ends and close enough
    function automatic logic segment_meets_circle(input logic signed [CW-1:0] sx,
                                                  input logic signed [CW-1:0] sy,
                                                  input logic signed [CW-1:0] ex,
                                                  input logic signed [CW-1:0] ey);
        longint vx, vy, wx, wy, ux, uy, cr, len2, rs;
        logic signed [127:0] lhs, rhs;
        if (holds_point(sx, sy) || holds_point(ex, ey)) return 1'b1;
        vx = longint'(ex) - longint'(sx);
        vy = longint'(ey) - longint'(sy);
        wx = longint'(ctr_x) - longint'(sx);
        wy = longint'(ctr_y) - longint'(sy);
        ux = longint'(ex) - longint'(ctr_x);
        uy = longint'(ey) - longint'(ctr_y);
        if (vx * wx + vy * wy <= 0) return 1'b0;
        if (vx * ux + vy * uy <= 0) return 1'b0;
        cr   = vx * wy - vy * wx;
        len2 = vx * vx + vy * vy;
        rs   = longint'(rad_sq);
        lhs  = 128'(cr);
        lhs  = lhs * lhs;
        rhs  = 128'(rs);
        rhs  = rhs * 128'(len2);
        return lhs < rhs;
    endfunction

    function automatic void grow_box(input logic signed [CW-1:0] px,
                                     input logic signed [CW-1:0] py);
        if (int'(px) < box_min_x) box_min_x = int'(px);
        if (int'(py) < box_min_y) box_min_y = int'(py);
        if (int'(px) > box_max_x) box_max_x = int'(px);
        if (int'(py) > box_max_y) box_max_y = int'(py);
    endfunction

    // advance the stroke state by one point and give the word it should produce
    function automatic t_seg_word step_stroke(input t_pen_point p);
        t_seg_word w;
        longint wd;
        w = '0;
        w.done = p.last;
        wd = longint'(pen_width);
        if (have_prev) begin
            w.seg_valid = 1'b1;
            w.seg_hit   = segment_meets_circle(prev_x, prev_y, p.x, p.y);
            w.cut       = w.seg_hit && !in_run;
            w.restart   = !w.seg_hit && in_run;
            in_run      = w.seg_hit;
            if (w.seg_hit) begin
                if (!box_valid) begin
                    box_min_x = int'(prev_x);
                    box_max_x = int'(prev_x);
                    box_min_y = int'(prev_y);
                    box_max_y = int'(prev_y);
                    box_valid = 1'b1;
                end
                grow_box(prev_x, prev_y);
                grow_box(p.x, p.y);
            end
        end
        if (p.last) begin
            if (box_valid) begin
                w.area_valid = 1'b1;
                w.min_x = clamp_coord(longint'(box_min_x) - wd);
                w.min_y = clamp_coord(longint'(box_min_y) - wd);
                w.max_x = clamp_coord(longint'(box_max_x) + wd);
                w.max_y = clamp_coord(longint'(box_max_y) + wd);
            end
            have_prev = 1'b0;
            in_run    = 1'b0;
            box_valid = 1'b0;
            box_min_x = 0;
            box_min_y = 0;
            box_max_x = 0;
            box_max_y = 0;
        end else begin
            have_prev = 1'b1;
        end
        prev_x = p.x;
        prev_y = p.y;
        return w;
    endfunction

    function automatic string fmt_word(input t_seg_word w);
        return $sformatf({"seg=%0b hit=%0b cut=%0b restart=%0b area=%0b ",
                          "(%0d,%0d)-(%0d,%0d) done=%0b"},
                         w.seg_valid, w.seg_hit, w.cut, w.restart, w.area_valid,
                         w.min_x, w.min_y, w.max_x, w.max_y, w.done);
    endfunction

    // point driver: payload changes on the falling edge, held while stalled
    always @(negedge i_clk) begin : drv_blk
        t_pen_point nxt;
        logic       go;
        if (i_rst_n) begin
            if (!i_in_valid || word_taken) begin
                go = (point_q.size() != 0) &&
                     (calm || $urandom_range(0, 99) >= IDLE_PCT);
                if (go) begin
                    nxt = point_q.pop_front();
                    i_point_x    <= nxt.x;
                    i_point_y    <= nxt.y;
                    i_last_point <= nxt.last;
                end
                i_in_valid <= go;
            end
            i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // result checker and predictor, both on the rising edge
    always @(posedge i_clk) begin : mon_blk
        t_seg_word got;
        t_seg_word want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_segment_valid, o_segment_hit, o_cut_here, o_restart_here,
                       o_area_valid, o_area_min_x, o_area_min_y, o_area_max_x,
                       o_area_max_y, o_stroke_done};
                if (due_words.size() == 0) begin
                    if (bad_words < 10)
                        $display("word %0d arrived with nothing pending: %s",
                                 words_seen, fmt_word(got));
                    bad_words++;
                end else begin
                    want = due_words.pop_front();
                    if (got !== want) begin
                        if (bad_words < 10)
                            $display("word %0d mismatch\n  exp %s\n  got %s",
                                     words_seen, fmt_word(want), fmt_word(got));
                        bad_words++;
                    end
                end
                words_seen++;
            end
            if (i_in_valid && !o_in_stall) begin
                want = step_stroke({i_point_x, i_point_y, i_last_point});
                due_words.push_back(want);
                n_strokes  += int'(want.done);
                n_hits     += int'(want.seg_hit);
                n_cuts     += int'(want.cut);
                n_restarts += int'(want.restart);
                n_areas    += int'(want.area_valid);
            end
            word_taken <= i_in_valid && !o_in_stall;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words pending", cycle_cnt,
                     due_words.size());
            $display("polyline_circle_eraser_core_tb: errors");
            $finish;
        end
    end

    task automatic push_point(input logic signed [CW-1:0] x,
                              input logic signed [CW-1:0] y, input logic last);
        point_q.push_back({x, y, last});
        queued_pts++;
    endtask

    // one stroke: mostly points scattered around the eraser, sometimes pure noise
    task automatic add_stroke(input int scale, input bit noisy);
        int n;
        logic signed [CW-1:0] x, y;
        logic [31:0] rnd;
        x = '0;
        y = '0;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
            if (k == 0 || $urandom_range(0, 9) != 0) begin
                if (noisy) begin
                    rnd = $urandom();
                    x = rnd[CW-1:0];
                    rnd = $urandom();
                    y = rnd[CW-1:0];
                end else begin
                    x = clamp_coord(longint'(ctr_x) +
                                    longint'($urandom_range(0, 2 * scale)) - scale);
                    y = clamp_coord(longint'(ctr_y) +
                                    longint'($urandom_range(0, 2 * scale)) - scale);
                end
            end
            // a repeated point gives a zero-length segment
            push_point(x, y, (k == n - 1) || (noisy && $urandom_range(0, 9) == 0));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_CENTER_X:  ctr_x = data[CW-1:0];
            CFG_CENTER_Y:  ctr_y = data[CW-1:0];
            CFG_RADIUS_SQ: rad_sq = data[RADIUS_W-1:0];
            CFG_STROKE_W:  pen_width = data[SWIDTH_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // upper data bits carry junk; a write past the register list follows
    task automatic setup_phase(input logic signed [CW-1:0] cx,
                               input logic signed [CW-1:0] cy,
                               input logic [31:0] rsq, input logic [SWIDTH_W-1:0] sw);
        logic [31:0] junk;
        logic [CFG_IDX_W-1:0] spare;
        junk = $urandom();
        write_reg(CFG_CENTER_X, {junk[31:CW], cx});
        write_reg(CFG_CENTER_Y, {~junk[31:CW], cy});
        write_reg(CFG_RADIUS_SQ, rsq);
        write_reg(CFG_STROKE_W, {junk[31:SWIDTH_W], sw});
        spare = CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, CFG_SPARE_FIRST));
        write_reg(spare, $urandom());
        n_settings++;
    endtask

    // wait until the block has nothing in flight
    task automatic settle();
        while (point_q.size() != 0 || i_in_valid || due_words.size() != 0)
            @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic fill_random(input int r, input int items);
        int start;
        start = queued_pts;
        while (queued_pts - start < items)
            add_stroke($urandom_range(r / 2 + 8, 2 * r + 32), $urandom_range(0, 99) < 25);
    endtask

    function automatic int pick_radius();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 16);
            1: return $urandom_range(16, 400);
            2: return $urandom_range(400, 4000);
            default: return $urandom_range(4000, 65535);
        endcase
    endfunction

    initial begin : seq_blk
        int r;
        logic [31:0] rnd;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: radius 100 around the origin, margin 50
        setup_phase(0, 0, 32'd10000, 12'd50);
        push_point(0, 0, 1'b1);                 // lone point, no segment
        push_point(-500, 0, 1'b0);
        push_point(500, 0, 1'b0);               // crosses via the perpendicular foot
        push_point(500, 500, 1'b0);             // clear again
        push_point(-500, -500, 1'b0);           // diagonal through the center
        push_point(-500, -500, 1'b0);           // zero length, outside
        push_point(30, 30, 1'b0);               // ends inside
        push_point(30, 30, 1'b0);               // zero length, inside
        push_point(32767, 32767, 1'b1);         // box top saturates
        push_point(-500, 100, 1'b0);
        push_point(500, 100, 1'b0);             // tangent line, not a hit
        push_point(100, 0, 1'b0);               // ends on the rim
        push_point(200, 0, 1'b0);
        push_point(500, 0, 1'b1);               // foot beyond the start
        push_point(-32768, -32768, 1'b0);
        push_point(32767, 32767, 1'b0);
        push_point(-32768, 32767, 1'b0);
        push_point(32767, -32768, 1'b1);        // box bottom saturates
        push_point(0, 99, 1'b0);
        push_point(0, -100, 1'b1);
        settle();

        // random settings
        r = pick_radius();
        rnd = $urandom();
        setup_phase(rnd[CW-1:0], rnd[31:32-CW], r * r + $urandom_range(0, 2 * r),
                    SWIDTH_W'($urandom_range(0, 400)));
        fill_random(r, 170);
        settle();

        // corner center, largest radius and margin
        setup_phase(-32768, 32767, 32'hFFFF_FFFF, 12'd4095);
        fill_random(65535, 170);
        settle();

        // no idling on either side for this stretch
        calm = 1'b1;
        r = pick_radius();
        rnd = $urandom();
        setup_phase(rnd[CW-1:0], rnd[31:32-CW], r * r,
                    SWIDTH_W'($urandom_range(0, 4095)));
        fill_random(r, 170);
        settle();
        calm = 1'b0;

        // zero radius: nothing can be hit
        rnd = $urandom();
        setup_phase(rnd[CW-1:0], rnd[31:32-CW], 32'd0, 12'd0);
        fill_random(64, 170);
        settle();

        r = pick_radius();
        setup_phase(32767, -32768, r * r + 1, SWIDTH_W'($urandom_range(0, 4095)));
        fill_random(r, 170);
        settle();

        $display("ran %0d points in %0d strokes over %0d eraser settings",
                 queued_pts, n_strokes, n_settings);
        $display("hits %0d, cuts %0d, restarts %0d, area reports %0d, mismatches %0d",
                 n_hits, n_cuts, n_restarts, n_areas, bad_words);
        if (bad_words == 0)
            $display("polyline_circle_eraser_core_tb: clean");
        else
            $display("polyline_circle_eraser_core_tb: errors");
        $finish;
    end

endmodule
